### sv/mbdm_pkg.sv
// Package with the shared types and codes of the motor bridge drive mapper.
package mbdm_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_WIRING_MODE   = 3'd0;
   localparam logic [2:0] CSR_SPEED_CEILING = 3'd1;
   localparam logic [2:0] CSR_SPEED_FLOOR   = 3'd2;
   localparam logic [2:0] CSR_REVERSE_DRIVE = 3'd3;
   localparam logic [2:0] CSR_BRAKE_ENABLE  = 3'd4;
   localparam logic [2:0] CSR_TIMEOUT_TICKS = 3'd5;

   // Wiring mode codes; the codes above the two-enable mode act as none.
   localparam logic [2:0] MODE_NONE       = 3'd0;
   localparam logic [2:0] MODE_SINGLE_PWM = 3'd1;
   localparam logic [2:0] MODE_TWO_PWM    = 3'd2;
   localparam logic [2:0] MODE_DIR_PWM    = 3'd3;
   localparam logic [2:0] MODE_TWO_ENABLE = 3'd4;

   // Input item codes.
   localparam logic ACTION_COMMAND = 1'b0;
   localparam logic ACTION_TICK    = 1'b1;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int IDLE_WIDTH     = 17;

   localparam logic [7:0]            LEVEL_FULL    = 8'hff;
   localparam logic [IDLE_WIDTH-1:0] IDLE_MAX      = {IDLE_WIDTH{1'b1}};
   localparam logic [15:0]           TIMEOUT_RESET = 16'd1000;
   localparam logic [7:0]            MAX_RESET     = 8'd255;

   typedef struct packed {
      logic [2:0]  wiring_mode;
      logic [7:0]  speed_ceiling;
      logic [7:0]  speed_floor;
      logic        reverse_drive;
      logic        brake_enable;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        action;
      logic        forward;
      logic [15:0] speed;
   } item_type;

   typedef struct packed {
      logic [8:0]            speed;
      logic [7:0]            forward_level;
      logic [7:0]            back_level;
      logic [7:0]            pwm_level;
      logic [7:0]            forward_pwm_level;
      logic [7:0]            back_duty_level;
      logic [IDLE_WIDTH-1:0] idle_ticks;
      logic                  armed;
   } state_type;

endpackage

### sv/mbdm_step.sv
// Combinational step: applies one command or tick to the drive state.
module mbdm_step
   import mbdm_pkg::*;
(
   input  item_type  item,
   input  cfg_type   cfg,
   input  state_type state,
   output state_type state_next,
   output logic      changed
);

   logic [IDLE_WIDTH-1:0] idle_inc;
   logic                  timeout_hit;
   logic                  apply_cmd;
   logic                  cmd_fwd;
   logic [15:0]           cmd_speed;
   logic signed [16:0]    req_ext;
   logic signed [16:0]    s_raw;
   logic signed [16:0]    s_clamp;
   logic signed [16:0]    mx_s;
   logic signed [16:0]    mn_s;
   logic signed [8:0]     s9;
   logic signed [8:0]     d;
   logic signed [8:0]     d_neg;
   logic [7:0]            d_abs;
   logic                  d_pos;
   logic                  d_zero;
   logic                  mode_valid;
   logic                  update;

   // Tick counting with saturation, and the forced stop on timeout.
   always_comb begin
      idle_inc    = (state.idle_ticks == IDLE_MAX) ? state.idle_ticks
                                                   : state.idle_ticks + 1'b1;
      timeout_hit = idle_inc > {1'b0, cfg.timeout_ticks};
      apply_cmd   = (item.action == ACTION_COMMAND) || (state.armed && timeout_hit);
      cmd_fwd     = (item.action == ACTION_COMMAND) ? item.forward : 1'b0;
      cmd_speed   = (item.action == ACTION_COMMAND) ? item.speed : 16'd0;
   end

   // Direction sign and clamping of a nonzero magnitude; the minimum wins.
   always_comb begin
      req_ext = {cmd_speed[15], cmd_speed};
      s_raw   = cmd_fwd ? req_ext : -req_ext;
      mx_s    = {9'd0, cfg.speed_ceiling};
      mn_s    = {9'd0, cfg.speed_floor};
      s_clamp = s_raw;
      if (s_raw < 0) begin
         if (s_clamp < -mx_s) s_clamp = -mx_s;
         if (s_clamp > -mn_s) s_clamp = -mn_s;
      end else if (s_raw > 0) begin
         if (s_clamp > mx_s) s_clamp = mx_s;
         if (s_clamp < mn_s) s_clamp = mn_s;
      end
      s9 = s_clamp[8:0];
   end

   // Drive value after the optional reversal.
   always_comb begin
      d      = cfg.reverse_drive ? -s9 : s9;
      d_neg  = -d;
      d_abs  = d[8] ? d_neg[7:0] : d[7:0];
      d_zero = (d == 9'sd0);
      d_pos  = !d[8] && !d_zero;
   end

   assign mode_valid = cfg.wiring_mode inside {[MODE_SINGLE_PWM:MODE_TWO_ENABLE]};
   assign update     = apply_cmd && mode_valid && (s9 != state.speed);
   assign changed    = update;

   // Next state: timeout bookkeeping, then the channels of the wiring mode.
   always_comb begin
      state_next = state;
      if (apply_cmd) begin
         state_next.idle_ticks = '0;
         state_next.armed      = 1'b1;
      end else if (item.action == ACTION_TICK && state.armed) begin
         state_next.idle_ticks = idle_inc;
      end
      if (update) begin
         state_next.speed = s9;
         case (cfg.wiring_mode)
            MODE_SINGLE_PWM: begin
               // (d + 256) >> 1 in offset binary.
               state_next.pwm_level = {~d[8], d[7:1]};
            end
            MODE_TWO_PWM: begin
               if (cfg.brake_enable && d_zero) begin
                  state_next.forward_level = LEVEL_FULL;
                  state_next.back_level    = LEVEL_FULL;
               end else begin
                  state_next.forward_level = d_pos ? d_abs : 8'd0;
                  state_next.back_level    = d[8] ? d_abs : 8'd0;
               end
            end
            MODE_DIR_PWM: begin
               if (cfg.brake_enable && d_zero) begin
                  state_next.forward_level = LEVEL_FULL;
                  state_next.back_level    = LEVEL_FULL;
                  state_next.pwm_level     = 8'd0;
               end else begin
                  state_next.forward_level = {7'd0, d_pos};
                  state_next.back_level    = {7'd0, d[8]};
                  if (!d_zero) state_next.pwm_level = d_abs;
               end
            end
            MODE_TWO_ENABLE: begin
               state_next.forward_level     = (!d_zero || cfg.brake_enable) ? LEVEL_FULL
                                                                            : 8'd0;
               state_next.back_level        = (!d_zero || cfg.brake_enable) ? LEVEL_FULL
                                                                            : 8'd0;
               state_next.forward_pwm_level = d[8] ? d_abs : 8'd0;
               state_next.back_duty_level   = d_pos ? d_abs : 8'd0;
            end
            default: begin
               state_next.speed = state.speed;
            end
         endcase
      end
   end

endmodule

### sv/motor_bridge_drive_mapper_top.sv
// Top level of the motor bridge drive mapper: registers, handshakes, config.
//
// Usage: the req channel carries items, either a speed command (action 0,
// with forward and a signed speed) or a one-millisecond tick (action 1).
// Every accepted item yields exactly one beat on the rsp channel, holding
// the stored speed, all held drive levels and a changed flag.
// The csr port writes one configuration register per cycle with csr_write;
// it is meant to be used only while no item is in flight.
// Timing: an item accepted at a clock edge lands in the input register, and
// its result moves on into the result register, which drives rsp_valid, as
// soon as that register is empty or being drained. Throughput is one item per
// cycle while the receiver takes every beat, set by the loop through the drive state registers.
// When the receiver stalls, the result register holds its beat; one more
// item can sit in the input register, and then req_ready drops until the
// result is taken.
// Synchronous reset empties both registers, clears the drive state and
// loads the configuration defaults (no wiring, max speed 255, min 0,
// timeout 1000 ticks).
module motor_bridge_drive_mapper_top
   import mbdm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic                      req_forward,
   input  logic signed [15:0]        req_speed,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [8:0]         rsp_current_speed,
   output logic [7:0]                rsp_forward_level,
   output logic [7:0]                rsp_back_level,
   output logic [7:0]                rsp_pwm_level,
   output logic [7:0]                rsp_forward_pwm_level,
   output logic [7:0]                rsp_back_duty_level,
   output logic                      rsp_changed,
   input  logic                      csr_write,
   input  logic [2:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   cfg_type   cfg_ff;
   item_type  item_ff;
   logic      item_valid_ff;
   logic      rsp_valid_ff;
   state_type state_ff;
   state_type state_in;
   state_type result_ff;
   logic      changed_ff;
   logic      changed_in;
   logic      out_open;
   logic      advance;

   // Handshake: the result register takes a beat when empty or being drained.
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_open;
   assign req_ready = !item_valid_ff || out_open;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wiring_mode   <= MODE_NONE;
         cfg_ff.speed_ceiling <= MAX_RESET;
         cfg_ff.speed_floor   <= 8'd0;
         cfg_ff.reverse_drive <= 1'b0;
         cfg_ff.brake_enable  <= 1'b0;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIRING_MODE:   cfg_ff.wiring_mode   <= csr_data[2:0];
            CSR_SPEED_CEILING: cfg_ff.speed_ceiling <= csr_data[7:0];
            CSR_SPEED_FLOOR:   cfg_ff.speed_floor   <= csr_data[7:0];
            CSR_REVERSE_DRIVE: cfg_ff.reverse_drive <= csr_data[0];
            CSR_BRAKE_ENABLE:  cfg_ff.brake_enable  <= csr_data[0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.action  <= req_action;
         item_ff.forward <= req_forward;
         item_ff.speed   <= req_speed;
      end
   end

   mbdm_step u_step (
      .item       (item_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .changed    (changed_in)
   );

   // Drive state, updated once for each item that moves to the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff  <= state_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_current_speed     = result_ff.speed;
   assign rsp_forward_level     = result_ff.forward_level;
   assign rsp_back_level        = result_ff.back_level;
   assign rsp_pwm_level         = result_ff.pwm_level;
   assign rsp_forward_pwm_level = result_ff.forward_pwm_level;
   assign rsp_back_duty_level   = result_ff.back_duty_level;
   assign rsp_changed           = changed_ff;

`ifndef NO_ASSERTIONS
   // A beat that rewrote the drive reports the speed now stored.
   a_changed_matches_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_changed) |-> (rsp_current_speed == state_ff.speed))
      else $error("changed beat does not match stored speed");

   // Without a wiring mode no beat may report a rewrite.
   a_no_change_without_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cfg_ff.wiring_mode == MODE_NONE || cfg_ff.wiring_mode > MODE_TWO_ENABLE))
      |-> !rsp_changed)
      else $error("drive rewritten with no wiring mode");

   // Ticks are not counted before the first command.
   a_idle_until_armed: assert property (@(posedge clock)
      !state_ff.armed |-> (state_ff.idle_ticks == '0))
      else $error("idle ticks counted before the first command");

   // The drive state moves only with a beat into the result register.
   a_state_moves_with_beat: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(state_ff))
      else $error("drive state changed without a beat");
`endif

endmodule

### tb/tb_motor_bridge_drive_mapper_top.sv
// Self-checking testbench for the motor bridge drive mapper top level.
`timescale 1ns / 1ps

module tb_motor_bridge_drive_mapper_top;
   import mbdm_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_ITEMS  = 150;
   localparam int REPORT_LIMIT = 10;

   // One result beat as the bridge reports it.
   typedef struct packed {
      logic [8:0] speed;
      logic [7:0] fwd;
      logic [7:0] back;
      logic [7:0] pwm;
      logic [7:0] fwd_pwm;
      logic [7:0] back_duty;
      logic       changed;
   } drive_levels_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_action = ACTION_TICK;
   logic                      req_forward = 1'b0;
   logic signed [15:0]        req_speed = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [8:0]         rsp_current_speed;
   logic [7:0]                rsp_forward_level;
   logic [7:0]                rsp_back_level;
   logic [7:0]                rsp_pwm_level;
   logic [7:0]                rsp_forward_pwm_level;
   logic [7:0]                rsp_back_duty_level;
   logic                      rsp_changed;
   logic                      csr_write = 1'b0;
   logic [2:0]                csr_index = CSR_WIRING_MODE;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Mirror of the bridge configuration and drive state.
   cfg_type               cfg_mirror;
   int                    held_speed;
   logic [7:0]            fwd_level;
   logic [7:0]            back_level;
   logic [7:0]            pwm_level;
   logic [7:0]            fwd_pwm_level;
   logic [7:0]            back_duty_level;
   logic [IDLE_WIDTH-1:0] idle_count;
   bit                    armed;

   item_type         pending_items[$];
   drive_levels_type expected_levels[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               mismatches = 0;
   int               stall_cycles = 0;
   int               last_speed = 0;

   motor_bridge_drive_mapper_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one speed command to the mirror; returns 1 when the drive was rewritten.
   function automatic bit apply_speed(bit fwd, int req);
      int s;
      int d;
      int mx;
      int mn;
      int mag;
      idle_count = '0;
      armed = 1'b1;
      if (cfg_mirror.wiring_mode == MODE_NONE || cfg_mirror.wiring_mode > MODE_TWO_ENABLE)
         return 1'b0;
      s = fwd ? req : -req;
      mx = int'(cfg_mirror.speed_ceiling);
      mn = int'(cfg_mirror.speed_floor);
      // The minimum clamp comes last, so it wins over a lower maximum.
      if (s < 0) begin
         if (s < -mx) s = -mx;
         if (s > -mn) s = -mn;
      end else if (s > 0) begin
         if (s > mx) s = mx;
         if (s < mn) s = mn;
      end
      if (s == held_speed)
         return 1'b0;
      held_speed = s;
      d = cfg_mirror.reverse_drive ? -s : s;
      mag = (d < 0) ? -d : d;
      case (cfg_mirror.wiring_mode)
         MODE_SINGLE_PWM: begin
            pwm_level = 8'((d + 256) / 2);
         end
         MODE_TWO_PWM: begin
            if (cfg_mirror.brake_enable && d == 0) begin
               fwd_level = LEVEL_FULL;
               back_level = LEVEL_FULL;
            end else begin
               fwd_level = (d > 0) ? 8'(mag) : 8'd0;
               back_level = (d < 0) ? 8'(mag) : 8'd0;
            end
         end
         MODE_DIR_PWM: begin
            if (cfg_mirror.brake_enable && d == 0) begin
               fwd_level = LEVEL_FULL;
               back_level = LEVEL_FULL;
               pwm_level = 8'd0;
            end else begin
               fwd_level = (d > 0) ? 8'd1 : 8'd0;
               back_level = (d < 0) ? 8'd1 : 8'd0;
               // The duty is held when the speed drops to zero without braking.
               if (d != 0) pwm_level = 8'(mag);
            end
         end
         MODE_TWO_ENABLE: begin
            fwd_level = (d != 0 || cfg_mirror.brake_enable) ? LEVEL_FULL : 8'd0;
            back_level = fwd_level;
            fwd_pwm_level = (d < 0) ? 8'(mag) : 8'd0;
            back_duty_level = (d > 0) ? 8'(mag) : 8'd0;
         end
         default: ;
      endcase
      return 1'b1;
   endfunction

   // Works out the beat that one accepted item yields and advances the mirror.
   function automatic drive_levels_type predict_beat(item_type it);
      drive_levels_type r;
      bit moved;
      moved = 1'b0;
      if (it.action == ACTION_COMMAND) begin
         moved = apply_speed(it.forward, int'($signed(it.speed)));
      end else if (armed) begin
         // A tick past the timeout acts as a zero-speed command.
         if (idle_count < IDLE_MAX) idle_count = idle_count + 1'b1;
         if (idle_count > {1'b0, cfg_mirror.timeout_ticks}) moved = apply_speed(1'b0, 0);
      end
      r.speed = 9'(held_speed);
      r.fwd = fwd_level;
      r.back = back_level;
      r.pwm = pwm_level;
      r.fwd_pwm = fwd_pwm_level;
      r.back_duty = back_duty_level;
      r.changed = moved;
      return r;
   endfunction

   // Random item: mostly modest speeds, with repeats, zeros and extremes mixed in.
   function automatic item_type random_item();
      item_type it;
      int pick;
      it.action = ($urandom_range(0, 9) < 4) ? ACTION_TICK : ACTION_COMMAND;
      it.forward = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      case (pick)
         0: last_speed = 0;
         1: last_speed = int'($urandom_range(0, 65534)) - 32767;
         2: ; // Repeating the last request often lands on the stored speed.
         3: last_speed = $urandom_range(0, 1) ? 32767 : -32767;
         default: last_speed = int'($urandom_range(0, 600)) - 300;
      endcase
      it.speed = 16'(last_speed);
      return it;
   endfunction

   task automatic note_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("Mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
   endtask

   task automatic queue_item(logic action, logic fwd, int speed);
      item_type it;
      it.action = action;
      it.forward = fwd;
      it.speed = 16'(speed);
      pending_items.push_back(it);
   endtask

   // Writes one register and keeps the mirror in step.
   task automatic write_csr(logic [2:0] idx, int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_WIDTH'(value);
      case (idx)
         CSR_WIRING_MODE:   cfg_mirror.wiring_mode = 3'(value);
         CSR_SPEED_CEILING: cfg_mirror.speed_ceiling = 8'(value);
         CSR_SPEED_FLOOR:   cfg_mirror.speed_floor = 8'(value);
         CSR_REVERSE_DRIVE: cfg_mirror.reverse_drive = 1'(value);
         CSR_BRAKE_ENABLE:  cfg_mirror.brake_enable = 1'(value);
         CSR_TIMEOUT_TICKS: cfg_mirror.timeout_ticks = 16'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic program_config(int mode, int mx, int mn, int rev, int brk, int tmo);
      write_csr(CSR_WIRING_MODE, mode);
      write_csr(CSR_SPEED_CEILING, mx);
      write_csr(CSR_SPEED_FLOOR, mn);
      write_csr(CSR_REVERSE_DRIVE, rev);
      write_csr(CSR_BRAKE_ENABLE, brk);
      write_csr(CSR_TIMEOUT_TICKS, tmo);
   endtask

   // Waits until every queued item is accepted and every beat is back.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_levels.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: presents queued items and predicts each accepted beat.
   always @(posedge clock) begin
      item_type next_item;
      item_type sent_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sent_item.action = req_action;
            sent_item.forward = req_forward;
            sent_item.speed = req_speed;
            expected_levels.push_back(predict_beat(sent_item));
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_action <= next_item.action;
               req_forward <= next_item.forward;
               req_speed <= next_item.speed;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each beat with the oldest expectation.
   always @(posedge clock) begin
      drive_levels_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               note_mismatch("beat with nothing expected", 0, 1);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_current_speed !== want.speed)
                  note_mismatch("current_speed", int'($signed(want.speed)),
                                int'(rsp_current_speed));
               if (rsp_forward_level !== want.fwd)
                  note_mismatch("forward_level", int'(want.fwd), int'(rsp_forward_level));
               if (rsp_back_level !== want.back)
                  note_mismatch("back_level", int'(want.back), int'(rsp_back_level));
               if (rsp_pwm_level !== want.pwm)
                  note_mismatch("pwm_level", int'(want.pwm), int'(rsp_pwm_level));
               if (rsp_forward_pwm_level !== want.fwd_pwm)
                  note_mismatch("forward_pwm_level", int'(want.fwd_pwm),
                                int'(rsp_forward_pwm_level));
               if (rsp_back_duty_level !== want.back_duty)
                  note_mismatch("back_duty_level", int'(want.back_duty),
                                int'(rsp_back_duty_level));
               if (rsp_changed !== want.changed)
                  note_mismatch("changed", int'(want.changed), int'(rsp_changed));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: ends the run when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus: directed cases, then random phases under varied settings.
   initial begin
      int mode;
      int mx;
      int mn;
      int tmo;
      int kind;
      cfg_mirror.wiring_mode = MODE_NONE;
      cfg_mirror.speed_ceiling = MAX_RESET;
      cfg_mirror.speed_floor = 8'd0;
      cfg_mirror.reverse_drive = 1'b0;
      cfg_mirror.brake_enable = 1'b0;
      cfg_mirror.timeout_ticks = TIMEOUT_RESET;
      held_speed = 0;
      fwd_level = '0;
      back_level = '0;
      pwm_level = '0;
      fwd_pwm_level = '0;
      back_duty_level = '0;
      idle_count = '0;
      armed = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: ticks before any command, then a command with no wiring.
      queue_item(ACTION_TICK, 1'b0, 0);
      queue_item(ACTION_TICK, 1'b1, -1);
      queue_item(ACTION_COMMAND, 1'b1, 100);
      queue_item(ACTION_TICK, 1'b0, 0);
      wait_drained();

      // Single pwm: full-scale requests, an unchanged speed and a quick timeout.
      program_config(MODE_SINGLE_PWM, 255, 0, 0, 0, 1);
      queue_item(ACTION_COMMAND, 1'b1, 32767);
      queue_item(ACTION_COMMAND, 1'b0, 32767);
      queue_item(ACTION_COMMAND, 1'b1, -32767);
      queue_item(ACTION_COMMAND, 1'b1, 0);
      queue_item(ACTION_COMMAND, 1'b1, 3);
      queue_item(ACTION_TICK, 1'b0, 0);
      queue_item(ACTION_TICK, 1'b0, 0);
      queue_item(ACTION_TICK, 1'b0, 0);
      wait_drained();

      // Direction lines: minimum above maximum, reversal, braking, zero timeout.
      program_config(MODE_DIR_PWM, 50, 200, 1, 1, 0);
      queue_item(ACTION_COMMAND, 1'b1, 10);
      queue_item(ACTION_COMMAND, 1'b0, 10);
      queue_item(ACTION_COMMAND, 1'b1, 0);
      queue_item(ACTION_TICK, 1'b0, 0);
      wait_drained();

      // Two pwm with braking and the longest timeout.
      program_config(MODE_TWO_PWM, 255, 0, 0, 1, 65535);
      queue_item(ACTION_COMMAND, 1'b0, 7);
      queue_item(ACTION_COMMAND, 1'b1, 0);
      queue_item(ACTION_COMMAND, 1'b1, -256);
      wait_drained();

      // Two enables without braking.
      write_csr(CSR_WIRING_MODE, MODE_TWO_ENABLE);
      write_csr(CSR_BRAKE_ENABLE, 0);
      queue_item(ACTION_COMMAND, 1'b1, 1);
      queue_item(ACTION_COMMAND, 1'b1, 0);
      queue_item(ACTION_COMMAND, 1'b1, -9);
      wait_drained();

      // A wiring code past the last mode behaves as no wiring.
      write_csr(CSR_WIRING_MODE, 6);
      queue_item(ACTION_COMMAND, 1'b1, 9);
      wait_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: program_config(MODE_SINGLE_PWM, 255, 0, 0, 0, 65535);
            1: program_config(MODE_TWO_ENABLE, 0, 255, 1, 1, 0);
            default: begin
               mode = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
               mx = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                : $urandom_range(1, 254);
               mn = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                : $urandom_range(0, 60);
               case ($urandom_range(0, 5))
                  0: tmo = 0;
                  1: tmo = 65535;
                  default: tmo = $urandom_range(1, 40);
               endcase
               program_config(mode, mx, mn, $urandom_range(0, 1), $urandom_range(0, 1), tmo);
            end
         endcase
         // Idling pattern rotates: none, sender idle, receiver stall, both light.
         kind = p % 4;
         send_idle_pct = (kind == 1) ? 85 : (kind == 3) ? 12 : 0;
         recv_stall_pct = (kind == 2) ? 85 : (kind == 3) ? 12 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++)
            pending_items.push_back(random_item());
         wait_drained();
      end

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
